/* src/mf3_pkg.sv */
// ============================================================================
// mf3_pkg: shared types and constants of the 3x3 median filter
// Register indexes, fixed field widths and the position tag that travels
// with each pixel through the window and sorting pipeline.
// ============================================================================
`default_nettype none

package mf3_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 10;
    localparam int MED_W      = 8;
    localparam int WIN_TAPS   = 9;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 11'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1
    } cfg_reg_t;

    // position tag of one request
    typedef struct packed {
        logic             produce;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

endpackage

`default_nettype wire

/* src/mf3_ram.sv */
// ============================================================================
// mf3_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (read-first).
// ============================================================================
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/mf3_scan.sv */
// ============================================================================
// mf3_scan: configuration and raster position tracking
// Holds the clamped frame extents, the row/column counters, and the first
// pipeline stage (pixel, line store address, position tag).
// ============================================================================
`default_nettype none

module mf3_scan #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             en,
    input  wire logic                             accept,
    input  wire logic [PIXEL_BITS-1:0]            pixel,
    input  wire logic                             frame_start,
    output logic      [$clog2(MAX_LINE)-1:0]      raddr,
    output logic                                  v1,
    output logic      [PIXEL_BITS-1:0]            px1,
    output logic      [$clog2(MAX_LINE)-1:0]      addr1,
    output mf3_pkg::pos_t                         pos1
);

    import mf3_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int EXT_W = $clog2(MAX_LINE + 1);
    localparam int CMP_W = (EXT_W > CFG_DATA_W) ? EXT_W : CFG_DATA_W;

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [CFG_DATA_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w < CMP_W'(3)) begin
            w = CMP_W'(3);
        end else if (w > CMP_W'(MAX_LINE)) begin
            w = CMP_W'(MAX_LINE);
        end
        return w[EXT_W-1:0];
    endfunction

    logic [EXT_W-1:0] rows_reg, cols_reg;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;

    logic             v1_reg;
    logic [PIXEL_BITS-1:0] px1_reg;
    logic [CNT_W-1:0] addr1_reg;
    pos_t             pos1_reg, pos_cur;

    logic             restart, row_last, col_last;
    logic [CNT_W-1:0] r, c, rm1, cm1;
    logic [CNT_W+POS_W-1:0] rm1_ext, cm1_ext;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= clamp_ext(CFG_RESET);
            cols_reg <= clamp_ext(CFG_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NUM_ROWS: rows_reg <= clamp_ext(cfg_data);
                CFG_NUM_COLS: cols_reg <= clamp_ext(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        restart = frame_start || (EXT_W'(row_cnt_reg) >= rows_reg)
                              || (EXT_W'(col_cnt_reg) >= cols_reg);
        r = restart ? '0 : row_cnt_reg;
        c = restart ? '0 : col_cnt_reg;

        row_last = (EXT_W'(r) == rows_reg - EXT_W'(1));
        col_last = (EXT_W'(c) == cols_reg - EXT_W'(1));

        if (col_last) begin
            col_cnt_next = '0;
            row_cnt_next = row_last ? '0 : r + CNT_W'(1);
        end else begin
            col_cnt_next = c + CNT_W'(1);
            row_cnt_next = r;
        end

        rm1     = r - CNT_W'(1);
        cm1     = c - CNT_W'(1);
        rm1_ext = {{POS_W{1'b0}}, rm1};
        cm1_ext = {{POS_W{1'b0}}, cm1};

        pos_cur.produce = (r >= CNT_W'(2)) && (c >= CNT_W'(2));
        pos_cur.last    = row_last && col_last;
        pos_cur.row     = rm1_ext[POS_W-1:0];
        pos_cur.col     = cm1_ext[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (accept) begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px1_reg   <= pixel;
            addr1_reg <= c;
            pos1_reg  <= pos_cur;
        end
    end

    assign raddr = c;
    assign v1    = v1_reg;
    assign px1   = px1_reg;
    assign addr1 = addr1_reg;
    assign pos1  = pos1_reg;

    a_frame_start_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_start |=> v1_reg && !pos1_reg.produce && addr1_reg == '0)
        else $error("frame start did not restart at the origin");

    a_last_is_result: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && pos1_reg.last |-> pos1_reg.produce)
        else $error("last-of-frame mark on a border pixel");

endmodule

`default_nettype wire

/* src/mf3_window.sv */
// ============================================================================
// mf3_window: line stores and 3x3 window
// Reads both line stores when a pixel is accepted, forwards the last write on an
// address match, writes back the shifted column and shifts the window.
// ============================================================================
`default_nettype none

module mf3_window #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         ren,
    input  wire logic [$clog2(MAX_LINE)-1:0]  raddr,
    input  wire logic                         v1,
    input  wire logic [PIXEL_BITS-1:0]        px1,
    input  wire logic [$clog2(MAX_LINE)-1:0]  addr1,
    input  wire mf3_pkg::pos_t                pos1,
    output logic      [PIXEL_BITS-1:0]        win [mf3_pkg::WIN_TAPS],
    output logic                              v2,
    output mf3_pkg::pos_t                     pos2
);

    import mf3_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE);

    logic [PIXEL_BITS-1:0] up_rd, lo_rd, up_f, lo_f;
    logic                  we;

    logic                  lw_valid_reg;
    logic [CNT_W-1:0]      lw_addr_reg;
    logic [PIXEL_BITS-1:0] lw_up_reg, lw_lo_reg;

    logic [PIXEL_BITS-1:0] win_reg [WIN_TAPS];
    logic                  v2_reg;
    pos_t                  pos2_reg;

    assign we = v1 && en;

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_LINE)) u_upper (
        .aclk  (aclk),
        .we    (we),
        .waddr (addr1),
        .wdata (lo_f),
        .re    (ren),
        .raddr (raddr),
        .rdata (up_rd)
    );

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_LINE)) u_lower (
        .aclk  (aclk),
        .we    (we),
        .waddr (addr1),
        .wdata (px1),
        .re    (ren),
        .raddr (raddr),
        .rdata (lo_rd)
    );

    // the write issued in the cycle of our read is not in the read data
    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == addr1)) begin
            up_f = lw_up_reg;
            lo_f = lw_lo_reg;
        end else begin
            up_f = up_rd;
            lo_f = lo_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (en) begin
            lw_valid_reg <= v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            lw_addr_reg <= addr1;
            lw_up_reg   <= lo_f;
            lw_lo_reg   <= px1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (we) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= up_f;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= lo_f;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= px1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1 && pos1.produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos2_reg <= pos1;
        end
    end

    assign win  = win_reg;
    assign v2   = v2_reg;
    assign pos2 = pos2_reg;

endmodule

`default_nettype wire

/* src/mf3_median.sv */
// ============================================================================
// mf3_median: pipelined median of nine
// Stage A sorts each window column, stage B takes the max of the lows,
// median of the mids and min of the highs; the median of those three is
// the median of all nine.
// ============================================================================
`default_nettype none

module mf3_median #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic [PIXEL_BITS-1:0]  win [mf3_pkg::WIN_TAPS],
    input  wire logic                   vin,
    input  wire mf3_pkg::pos_t          posin,
    output logic      [PIXEL_BITS-1:0]  med,
    output logic                        vout,
    output mf3_pkg::pos_t               posout
);

    import mf3_pkg::*;

    localparam int W = PIXEL_BITS;

    function automatic logic [W-1:0] min2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [W-1:0] max2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [W-1:0] med3(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [W-1:0] lo_reg [3], mid_reg [3], hi_reg [3];
    logic [W-1:0] mx_reg, md_reg, mn_reg;
    logic         va_reg, vb_reg;
    pos_t         posa_reg, posb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                lo_reg[k]  <= min2(min2(win[k], win[k+3]), win[k+6]);
                mid_reg[k] <= med3(win[k], win[k+3], win[k+6]);
                hi_reg[k]  <= max2(max2(win[k], win[k+3]), win[k+6]);
            end
            mx_reg   <= max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]);
            md_reg   <= med3(mid_reg[0], mid_reg[1], mid_reg[2]);
            mn_reg   <= min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]);
            posa_reg <= posin;
            posb_reg <= posa_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= vin;
            vb_reg <= va_reg;
        end
    end

    assign med    = med3(mx_reg, md_reg, mn_reg);
    assign vout   = vb_reg;
    assign posout = posb_reg;

endmodule

`default_nettype wire

/* src/median_filter_3x3.sv */
// ============================================================================
// median_filter_3x3: streaming 3x3 median filter over a raster frame
// Line stores in RAM, a 3x3 window and a pipelined median network.
// ============================================================================
// Pipeline: the pixel that completes a window passes the scan stage, the
//   window, median stages A and B and the output register in that order.
// Throughput: one pixel per cycle, set by the single read and write port
//   per line store; the whole pipeline holds while the result is stalled.
// Reset: extents 100 x 100, counters and window cleared; line stores are
//   not cleared, pixels are accepted as soon as reset is released.
`default_nettype none

module median_filter_3x3 #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // tdata: pixel
    input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: frame_start
    input  wire logic                                  s_axis_tuser,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: median[7:0], out_row[17:8], out_col[27:18], zero fill
    output logic [mf3_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
    output logic                                       m_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import mf3_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int PAD_W = OUT_DATA_W - MED_W - 2 * POS_W;

    logic                  en, accept;
    logic [CNT_W-1:0]      raddr, addr1;
    logic                  v1, v2, vmed;
    logic [PIXEL_BITS-1:0] px1, med;
    logic [PIXEL_BITS+MED_W-1:0] med_ext;
    pos_t                  pos1, pos2, posmed;
    logic [PIXEL_BITS-1:0] win [WIN_TAPS];

    logic                  m_valid_reg;
    logic [MED_W-1:0]      m_med_reg;
    pos_t                  m_pos_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign cfg_ready     = 1'b1;

    mf3_scan #(.MAX_LINE(MAX_LINE), .PIXEL_BITS(PIXEL_BITS)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .en          (en),
        .accept      (accept),
        .pixel       (s_axis_tdata[PIXEL_BITS-1:0]),
        .frame_start (s_axis_tuser),
        .raddr       (raddr),
        .v1          (v1),
        .px1         (px1),
        .addr1       (addr1),
        .pos1        (pos1)
    );

    mf3_window #(.MAX_LINE(MAX_LINE), .PIXEL_BITS(PIXEL_BITS)) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ren     (accept),
        .raddr   (raddr),
        .v1      (v1),
        .px1     (px1),
        .addr1   (addr1),
        .pos1    (pos1),
        .win     (win),
        .v2      (v2),
        .pos2    (pos2)
    );

    mf3_median #(.PIXEL_BITS(PIXEL_BITS)) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .win     (win),
        .vin     (v2),
        .posin   (pos2),
        .med     (med),
        .vout    (vmed),
        .posout  (posmed)
    );

    assign med_ext = {{MED_W{1'b0}}, med};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vmed;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_med_reg <= med_ext[MED_W-1:0];
            m_pos_reg <= posmed;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_pos_reg.last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_pos_reg.col, m_pos_reg.row, m_med_reg};

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("pixel accepted while the result is stalled");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_pos_reg))
        else $error("stalled result changed");

    a_result_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(vmed) && $past(en))
        else $error("result without a pipeline request");

endmodule

`default_nettype wire

/* tb/tb_median_filter_3x3.sv */
// ============================================================================
// tb_median_filter_3x3: self-checking bench for the 3x3 median filter
// Streams frames of pixels through the filter under bursty input and a
// stalling sink, predicts each interior median with its position and
// last-of-frame mark, and compares every result in order.
// ============================================================================
`default_nettype none

module tb_median_filter_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_PIXELS = 900;
    localparam int LINE_DEPTH    = 1024;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {PX_RANDOM, PX_EXTREME, PX_CLUSTER, PX_FLAT} px_style_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       sof;
    } pixel_req_t;

    typedef struct packed {
        logic [MED_W-1:0] median;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } filt_res_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    median_filter_3x3 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    logic [CFG_DATA_W-1:0] reg_rows = CFG_RESET;
    logic [CFG_DATA_W-1:0] reg_cols = CFG_RESET;
    logic [7:0]            line_up [LINE_DEPTH];
    logic [7:0]            line_lo [LINE_DEPTH];
    logic [8:0][7:0]       win      = '0;
    int                    row_cnt  = 0;
    int                    col_cnt  = 0;

    pixel_req_t pend_q[$];
    filt_res_t  median_q[$];

    int   errors    = 0;
    int   cycles    = 0;
    int   cfg_fires = 0;
    int   hold_reqs = 0;
    logic s_fired   = 1'b0;

    function automatic int extent_of(logic [CFG_DATA_W-1:0] v);
        if (v < 3) return 3;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return int'(v);
    endfunction

    function automatic logic [7:0] median9(logic [8:0][7:0] w);
        logic [7:0] s [9];
        logic [7:0] t;
        int i, j;
        for (i = 0; i < 9; i++) s[i] = w[i];
        for (i = 0; i < 8; i++)
            for (j = 0; j < 8 - i; j++)
                if (s[j] > s[j+1]) begin
                    t      = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = t;
                end
        return s[4];
    endfunction

    task filter_pixel(input logic [7:0] px, input logic sof);
        int rows_e, cols_e;
        logic [7:0] up, lo;
        filt_res_t res;
        rows_e = extent_of(reg_rows);
        cols_e = extent_of(reg_cols);
        // counters left past a shrunk extent restart the frame too
        if (sof || row_cnt >= rows_e || col_cnt >= cols_e) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        up  = line_up[col_cnt];
        lo  = line_lo[col_cnt];
        win = {px, win[8], win[7], lo, win[5], win[4], up, win[2], win[1]};
        line_up[col_cnt] = lo;
        line_lo[col_cnt] = px;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            res.median = median9(win);
            res.row    = POS_W'(row_cnt - 1);
            res.col    = POS_W'(col_cnt - 1);
            res.last   = (row_cnt == rows_e - 1) && (col_cnt == cols_e - 1);
            median_q.push_back(res);
        end
        col_cnt++;
        if (col_cnt >= cols_e) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= rows_e) row_cnt = 0;
        end
    endtask

    task flag_error(input string msg);
        if (errors < 10) $display("%s", msg);
        errors++;
    endtask

    task check_result();
        filt_res_t want;
        if (median_q.size() == 0) begin
            flag_error($sformatf("unexpected result: tdata=%h tlast=%b",
                                 m_axis_tdata, m_axis_tlast));
        end else begin
            want = median_q.pop_front();
            if (m_axis_tdata[MED_W-1:0] !== want.median
                || m_axis_tdata[MED_W+POS_W-1:MED_W] !== want.row
                || m_axis_tdata[MED_W+2*POS_W-1:MED_W+POS_W] !== want.col
                || m_axis_tdata[OUT_DATA_W-1:MED_W+2*POS_W] !== '0
                || m_axis_tlast !== want.last) begin
                flag_error($sformatf(
                    "mismatch: expected median %0d row %0d col %0d last %b, got %0d %0d %0d %b fill %h",
                    want.median, want.row, want.col, want.last,
                    m_axis_tdata[MED_W-1:0], m_axis_tdata[MED_W+POS_W-1:MED_W],
                    m_axis_tdata[MED_W+2*POS_W-1:MED_W+POS_W], m_axis_tlast,
                    m_axis_tdata[OUT_DATA_W-1:MED_W+2*POS_W]));
            end
        end
    endtask

    // sample all handshakes at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fired <= 1'b0;
        end else begin
            s_fired <= s_axis_tvalid && s_axis_tready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_NUM_ROWS) reg_rows = cfg_data;
                else if (cfg_index == CFG_NUM_COLS) reg_cols = cfg_data;
                cfg_fires <= cfg_fires + 1;
            end
            if (s_axis_tvalid && s_axis_tready) filter_pixel(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) check_result();
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // pixel driver: bursts of random length, random gaps in between
    pixel_req_t drv_req;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_fired) begin
            // request still pending
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
            drv_req = pend_q.pop_front();
            s_axis_tdata  <= drv_req.pixel;
            s_axis_tuser  <= drv_req.sof;
            s_axis_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 48);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // sink: the stall pattern is redrawn at random, plus long hold-offs
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_tick   = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(negedge aclk) begin
        rx_tick++;
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    task push_frame(input int n_px, input logic sof_first, input px_style_t style);
        pixel_req_t r;
        logic [7:0] base;
        int k;
        base = 8'($urandom_range(0, 255));
        for (k = 0; k < n_px; k++) begin
            case (style)
                PX_RANDOM:  r.pixel = 8'($urandom_range(0, 255));
                PX_EXTREME: r.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                PX_CLUSTER: r.pixel = base + 8'($urandom_range(0, 3));
                default:    r.pixel = base;
            endcase
            // rare restart in mid-frame
            r.sof = (k == 0) ? sof_first : ($urandom_range(0, 399) == 0);
            pend_q.push_back(r);
        end
    endtask

    task drain();
        while (pend_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (median_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int n;
        @(negedge aclk);
        n = cfg_fires;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (cfg_fires == n);
        cfg_valid <= 1'b0;
    endtask

    int   rand_px = 0;
    int   old_cols_e, n_px, frames, f;
    logic safe, sof;
    logic [CFG_DATA_W-1:0] rows_v, cols_v;

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset extents: 100 x 100
        push_frame(300, 1'b1, PX_RANDOM);
        drain();

        // counters sit at row 3, past the new extent, so no frame start needed
        write_reg(CFG_NUM_ROWS, 11'd3);
        write_reg(CFG_NUM_COLS, 11'd3);
        push_frame(9, 1'b0, PX_EXTREME);
        push_frame(9, 1'b0, PX_FLAT);
        drain();

        // extents below the minimum clamp up
        write_reg(CFG_NUM_ROWS, 11'd0);
        write_reg(CFG_NUM_COLS, 11'd2);
        push_frame(9, 1'b1, PX_RANDOM);
        drain();

        // first 128 rows of the tallest frame, sink held off meanwhile
        write_reg(CFG_NUM_ROWS, 11'd1024);
        write_reg(CFG_NUM_COLS, 11'd3);
        push_frame(384, 1'b1, PX_RANDOM);
        repeat (40) @(posedge aclk);
        hold_reqs++;
        drain();

        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));

        while (rand_px < RANDOM_PIXELS) begin
            old_cols_e = extent_of(reg_cols);
            case ($urandom_range(0, 9))
                0: begin
                    rows_v = CFG_DATA_W'($urandom_range(0, 2047));
                    cols_v = CFG_DATA_W'($urandom_range(0, 12));
                end
                1: begin
                    rows_v = CFG_DATA_W'($urandom_range(0, 8));
                    cols_v = CFG_DATA_W'($urandom_range(0, 2047));
                end
                default: begin
                    rows_v = CFG_DATA_W'($urandom_range(3, 10));
                    cols_v = CFG_DATA_W'($urandom_range(3, 24));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_NUM_ROWS, rows_v);
                write_reg(CFG_NUM_COLS, cols_v);
            end else begin
                write_reg(CFG_NUM_COLS, cols_v);
                write_reg(CFG_NUM_ROWS, rows_v);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom));

            // carrying on mid-frame into wider rows would read stale line entries
            safe = (row_cnt == 0 && col_cnt == 0)
                || row_cnt >= extent_of(reg_rows)
                || col_cnt >= extent_of(reg_cols)
                || extent_of(reg_cols) <= old_cols_e;

            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                n_px = extent_of(reg_rows) * extent_of(reg_cols);
                if (n_px > 300) n_px = int'($urandom_range(30, 300));
                else if ($urandom_range(0, 7) == 0) n_px = int'($urandom_range(1, n_px));
                sof = (f == 0 && !safe) ? 1'b1 : ($urandom_range(0, 3) != 0);
                push_frame(n_px, sof, px_style_t'($urandom_range(0, 3)));
                rand_px += n_px;
            end
            drain();
        end

        if (errors == 0 && median_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* median_filter_3x3.f */
src/mf3_pkg.sv
src/mf3_ram.sv
src/mf3_scan.sv
src/mf3_window.sv
src/mf3_median.sv
src/median_filter_3x3.sv
tb/tb_median_filter_3x3.sv
